[rtl/core/knps_pkg.sv]
// shared types and constants of the k-nearest point selector
// used by knps_dist, knps_cell and k_nearest_point_selector; no dependencies
package knps_pkg;

    localparam int COORD_W = 16;
    localparam int ID_W    = 32;
    localparam int DIST_W  = 34;
    localparam int SQ_W    = 32;

    // configuration register indexes
    localparam logic CFG_QUERY_X = 1'b0;
    localparam logic CFG_QUERY_Y = 1'b1;

    // one kept neighbor
    typedef struct packed {
        logic [DIST_W-1:0] sq_dist;
        logic [ID_W-1:0]   id;
        logic              filled;
    } t_slot;

    localparam t_slot SLOT_EMPTY = '{sq_dist: {DIST_W{1'b1}}, id: '0, filled: 1'b0};

    // candidate point leaving the distance pipeline
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [DIST_W-1:0] sq_dist;
        logic [ID_W-1:0]   id;
    } t_cand;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_DRAIN,
        ST_READ
    } t_state;

endpackage

[rtl/core/knps_dist.sv]
// three-stage squared euclidean distance pipeline
// depends on knps_pkg
module knps_dist (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [knps_pkg::COORD_W-1:0] i_x,
    input  logic signed [knps_pkg::COORD_W-1:0] i_y,
    input  logic        [knps_pkg::ID_W-1:0]    i_id,
    input  logic                                i_last,
    input  logic signed [knps_pkg::COORD_W-1:0] i_query_x,
    input  logic signed [knps_pkg::COORD_W-1:0] i_query_y,
    output knps_pkg::t_cand                     o_cand
);

    localparam int DW = knps_pkg::COORD_W + 1;

    logic signed [DW-1:0]              r_dx, r_dy;
    logic [knps_pkg::ID_W-1:0]         r_id1, r_id2, r_id3;
    logic                              r_v1, r_v2, r_v3;
    logic                              r_l1, r_l2, r_l3;
    logic [knps_pkg::SQ_W-1:0]         r_sqx, r_sqy;
    logic [knps_pkg::DIST_W-1:0]       r_dist;
    logic [DW-1:0]                     n_ax, n_ay;

    // absolute differences, which fit in the coordinate width
    always_comb begin
        n_ax = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
        n_ay = r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);
    end

    // stage valid and marker bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // payload stages: difference, square, sum
    always_ff @(posedge i_clk) begin
        r_dx   <= DW'(i_x) - DW'(i_query_x);
        r_dy   <= DW'(i_y) - DW'(i_query_y);
        r_id1  <= i_id;
        r_l1   <= i_last;
        r_sqx  <= n_ax[knps_pkg::COORD_W-1:0] * n_ax[knps_pkg::COORD_W-1:0];
        r_sqy  <= n_ay[knps_pkg::COORD_W-1:0] * n_ay[knps_pkg::COORD_W-1:0];
        r_id2  <= r_id1;
        r_l2   <= r_l1;
        r_dist <= knps_pkg::DIST_W'(r_sqx) + knps_pkg::DIST_W'(r_sqy);
        r_id3  <= r_id2;
        r_l3   <= r_l2;
    end

    assign o_cand = '{valid: r_v3, last: r_l3, sq_dist: r_dist, id: r_id3};

endmodule

[rtl/core/knps_cell.sv]
// one slot of the sorted insertion chain
// depends on knps_pkg
module knps_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  knps_pkg::t_cell_ctl  i_ctl,
    input  knps_pkg::t_cand      i_cand,
    input  knps_pkg::t_slot      i_left_slot,
    input  logic                 i_left_le,
    input  knps_pkg::t_slot      i_right_slot,
    output knps_pkg::t_slot      o_slot,
    output logic                 o_le
);

    logic [knps_pkg::DIST_W-1:0] r_sq_dist;
    logic [knps_pkg::ID_W-1:0]   r_id;
    logic                        r_filled;
    knps_pkg::t_slot             n_slot;

    assign o_slot = '{sq_dist: r_sq_dist, id: r_id, filled: r_filled};

    // this slot ranks at or ahead of the candidate; empty slots never do
    assign o_le = (r_sq_dist <= i_cand.sq_dist);

    // keep, take the candidate, take the left neighbor's slot, or on a shift take the right neighbor's slot
    always_comb begin
        n_slot = o_slot;
        if (i_ctl.shift) begin
            n_slot = i_right_slot;
        end else if (i_ctl.insert && !o_le) begin
            if (i_left_le) begin
                n_slot = '{sq_dist: i_cand.sq_dist, id: i_cand.id, filled: 1'b1};
            end else begin
                n_slot = i_left_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_dist <= knps_pkg::SLOT_EMPTY.sq_dist;
            r_filled  <= 1'b0;
        end else begin
            r_sq_dist <= n_slot.sq_dist;
            r_filled  <= n_slot.filled;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_slot.id;
    end

endmodule

[rtl/core/k_nearest_point_selector.sv]
// k-nearest point selector top level: distance pipeline, cell chain, readout control
// depends on knps_pkg, knps_dist and knps_cell
//
// Keeps the NEIGHBOR_COUNT points nearest the query point, sorted by squared
// distance, earlier arrival first among equals; a point enters only when it is
// strictly closer than the worst kept slot. Points are taken one per cycle
// while collecting and pass a three-stage distance pipeline into a row of
// cells that all compare against the new distance and shift in the same cycle.
// A transfer with tlast set closes the search: input stalls while that point
// reaches the chain, then NEIGHBOR_COUNT results are shifted out of cell 0,
// one per output transfer, emptying the chain; the next point is taken once
// the last result has gone. Empty slots read out with id 0, distance all ones
// and tuser low. Configuration writes belong between searches.
module k_nearest_point_selector #(
    parameter int NEIGHBOR_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // point stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // point_x[15:0], point_y[31:16], point_id[63:32]
    input  logic        s_axis_tlast,   // final_point
    // neighbor stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // neighbor_id[31:0], neighbor_dist[65:32], zero[71:66]
    output logic        m_axis_tuser,   // neighbor_valid
    output logic        m_axis_tlast    // run_end
);

    localparam int CNT_W = (NEIGHBOR_COUNT > 1) ? $clog2(NEIGHBOR_COUNT) : 1;

    logic signed [knps_pkg::COORD_W-1:0] r_query_x, r_query_y;
    knps_pkg::t_state    r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    knps_pkg::t_cand     s_cand;
    knps_pkg::t_cell_ctl s_ctl;
    knps_pkg::t_slot     s_slot [NEIGHBOR_COUNT];
    logic                s_le   [NEIGHBOR_COUNT];
    logic                s_in_xfer, s_out_xfer;

    // query registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_x <= '0;
            r_query_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                knps_pkg::CFG_QUERY_X: r_query_x <= i_cfg_wdata;
                knps_pkg::CFG_QUERY_Y: r_query_y <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign s_out_xfer = m_axis_tvalid && m_axis_tready;

    knps_dist u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_in_xfer),
        .i_x       (s_axis_tdata[15:0]),
        .i_y       (s_axis_tdata[31:16]),
        .i_id      (s_axis_tdata[63:32]),
        .i_last    (s_axis_tlast),
        .i_query_x (r_query_x),
        .i_query_y (r_query_y),
        .o_cand    (s_cand)
    );

    // insertion on every candidate, shift toward the output on every readout transfer
    assign s_ctl = '{insert: s_cand.valid, shift: s_out_xfer};

    // row of cells, cell 0 holds the nearest point
    for (genvar g = 0; g < NEIGHBOR_COUNT; g++) begin : g_cell
        knps_pkg::t_slot s_left_slot, s_right_slot;
        logic            s_left_le;

        if (g == 0) begin : g_head
            assign s_left_slot = knps_pkg::SLOT_EMPTY;
            assign s_left_le   = 1'b1;
        end else begin : g_body
            assign s_left_slot = s_slot[g-1];
            assign s_left_le   = s_le[g-1];
        end

        if (g == NEIGHBOR_COUNT - 1) begin : g_tail
            assign s_right_slot = knps_pkg::SLOT_EMPTY;
        end else begin : g_inner
            assign s_right_slot = s_slot[g+1];
        end

        knps_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (s_ctl),
            .i_cand       (s_cand),
            .i_left_slot  (s_left_slot),
            .i_left_le    (s_left_le),
            .i_right_slot (s_right_slot),
            .o_slot       (s_slot[g]),
            .o_le         (s_le[g])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= knps_pkg::ST_COLLECT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and handshake outputs
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (r_state)
            knps_pkg::ST_COLLECT: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && s_axis_tlast) begin
                    n_state = knps_pkg::ST_DRAIN;
                end
            end
            knps_pkg::ST_DRAIN: begin
                if (s_cand.valid && s_cand.last) begin
                    n_state = knps_pkg::ST_READ;
                    n_cnt   = '0;
                end
            end
            knps_pkg::ST_READ: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(NEIGHBOR_COUNT - 1)) begin
                        n_state = knps_pkg::ST_COLLECT;
                        n_cnt   = '0;
                    end
                end
            end
            default: begin
                n_state = knps_pkg::ST_COLLECT;
                n_cnt   = '0;
            end
        endcase
    end

    // result taken straight from the head cell
    assign m_axis_tdata = {6'b0, s_slot[0].sq_dist,
                           s_slot[0].filled ? s_slot[0].id : {knps_pkg::ID_W{1'b0}}};
    assign m_axis_tuser = s_slot[0].filled;
    assign m_axis_tlast = (r_cnt == CNT_W'(NEIGHBOR_COUNT - 1));

endmodule
